// ----- design/uaisd_pkg.sv -----
// uaisd_pkg: shared types and codes for the unsorted array insert/search/delete block.
// No dependencies; used by uaisd_front, uaisd_back and the top level.
package uaisd_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int FILL_W  = 7;

    // action codes on the input channel
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // status codes on the result channel
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // classified command handed from front to back
    typedef struct packed {
        logic               ins;
        logic               look;
        logic               del;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [FILL_W-1:0] fill_count;
    } res_t;

endpackage

// ----- design/uaisd_front.sv -----
// uaisd_front: accepts input transactions, decodes the action and queues them (2 deep).
// Depends on uaisd_pkg.
module uaisd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_action,
    input  logic [uaisd_pkg::VALUE_W-1:0] s_value,
    output logic                          cmd_valid,
    output uaisd_pkg::cmd_t               cmd,
    input  logic                          cmd_pop
);

    uaisd_pkg::cmd_t ent_reg [2];
    logic            wp_reg;
    logic            rp_reg;
    logic [1:0]      cnt_reg;
    uaisd_pkg::cmd_t dec;
    logic            push;
    logic            pop;

    always_comb begin
        dec       = '0;
        dec.value = s_value;
        unique case (s_action)
            uaisd_pkg::ACT_INSERT: dec.ins  = 1'b1;
            uaisd_pkg::ACT_SEARCH: dec.look = 1'b1;
            uaisd_pkg::ACT_DELETE: begin
                dec.look = 1'b1;
                dec.del  = 1'b1;
            end
            default: ;
        endcase
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = ent_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ----- design/uaisd_back.sv -----
// uaisd_back: executes queued commands on the entry memory: append, linear scan, shift-down.
// Depends on uaisd_pkg.
module uaisd_back #(
    parameter int CAPACITY = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  uaisd_pkg::cmd_t cmd,
    output logic            cmd_pop,
    output logic            res_valid,
    output uaisd_pkg::res_t res,
    input  logic            res_ready
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = uaisd_pkg::VALUE_W;
    localparam int PW = uaisd_pkg::POS_W;
    localparam int FW = uaisd_pkg::FILL_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [VW-1:0] mem [CAPACITY];
    logic [VW-1:0] rdata_reg;

    logic [1:0]    state_reg,   state_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [VW-1:0] key_reg,     key_next;
    logic          del_reg,     del_next;
    logic [CW-1:0] iss_reg,     iss_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] pos_reg,     pos_next;
    logic [CW-1:0] sh_rd_reg,   sh_rd_next;
    logic [AW-1:0] wr_idx_reg,  wr_idx_next;
    logic          wr_vld_reg,  wr_vld_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [VW-1:0] mem_wd;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          hit;

    assign hit = cmp_vld_reg && (rdata_reg == key_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        del_next     = del_reg;
        iss_next     = iss_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        pos_next     = pos_reg;
        sh_rd_next   = sh_rd_reg;
        wr_idx_next  = wr_idx_reg;
        wr_vld_next  = wr_vld_reg;
        cmd_pop      = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        res.status   = uaisd_pkg::ST_DONE;
        res.fill_count = FW'(count_reg);
        mem_we       = 1'b0;
        mem_wa       = count_reg[AW-1:0];
        mem_wd       = cmd.value;
        rd_en        = 1'b0;
        rd_addr      = iss_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid && res_ready) begin
                    cmd_pop = 1'b1;
                    if (cmd.ins) begin
                        res_valid = 1'b1;
                        if (count_reg == CAP_C) begin
                            res.status = uaisd_pkg::ST_FULL;
                        end else begin
                            mem_we         = 1'b1;
                            res.position   = PW'(count_reg);
                            count_next     = count_reg + CW'(1);
                            res.fill_count = FW'(count_reg + CW'(1));
                        end
                    end else if (cmd.look) begin
                        key_next = cmd.value;
                        del_next = cmd.del;
                        if (count_reg == '0) begin
                            res_valid  = 1'b1;
                            res.status = uaisd_pkg::ST_MISSING;
                        end else begin
                            iss_next     = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                    end else begin
                        res_valid = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (!del_reg) begin
                        if (res_ready) begin
                            res_valid    = 1'b1;
                            res.found    = 1'b1;
                            res.position = PW'(cmp_idx_reg);
                            state_next   = S_IDLE;
                        end
                    end else begin
                        pos_next    = cmp_idx_reg;
                        sh_rd_next  = CW'(cmp_idx_reg) + CW'(1);
                        wr_vld_next = 1'b0;
                        state_next  = S_SHIFT;
                    end
                end else if (cmp_vld_reg && (iss_reg == count_reg)) begin
                    if (res_ready) begin
                        res_valid  = 1'b1;
                        res.status = uaisd_pkg::ST_MISSING;
                        state_next = S_IDLE;
                    end
                end else begin
                    rd_en        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_reg[AW-1:0];
                    iss_next     = iss_reg + CW'(1);
                end
            end
            S_SHIFT: begin
                mem_wa = wr_idx_reg;
                mem_wd = rdata_reg;
                mem_we = wr_vld_reg;
                if (sh_rd_reg < count_reg) begin
                    rd_en       = 1'b1;
                    rd_addr     = sh_rd_reg[AW-1:0];
                    wr_vld_next = 1'b1;
                    wr_idx_next = AW'(sh_rd_reg - CW'(1));
                    sh_rd_next  = sh_rd_reg + CW'(1);
                end else begin
                    wr_vld_next = 1'b0;
                    if (!wr_vld_reg && res_ready) begin
                        res_valid      = 1'b1;
                        res.found      = 1'b1;
                        res.position   = PW'(pos_reg);
                        count_next     = count_reg - CW'(1);
                        res.fill_count = FW'(count_reg - CW'(1));
                        state_next     = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        del_reg     <= del_next;
        iss_reg     <= iss_next;
        cmp_idx_reg <= cmp_idx_next;
        pos_reg     <= pos_next;
        sh_rd_reg   <= sh_rd_next;
        wr_idx_reg  <= wr_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            wr_vld_reg  <= wr_vld_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("fill count above capacity");

    a_res_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res_ready)
        else $error("result issued while output register busy");

    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && wr_vld_reg) |-> (CW'(wr_idx_reg) + CW'(1) < count_reg))
        else $error("shift write outside stored entries");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_next != count_reg) |-> res_valid)
        else $error("fill count changed without a result");
`endif

endmodule

// ----- design/unsorted_array_insert_search_delete.sv -----
// Insert, unused action or lookup on an empty table: answered from the idle state without a scan.
// Search: linear scan from position 0 to the first hit, or over all stored entries on a miss
// (one entry a cycle, bounded by the single read port of the entry memory). Delete: the same
// scan, then every later entry moved down one place, one entry a cycle. The back end runs one
// transaction at a time; a 2-deep command queue and the result register decouple both channels.
// Reset (aresetn, synchronous, active low) empties the table; the memory itself is not cleared.
module unsorted_array_insert_search_delete #(
    parameter int CAPACITY = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_action,
    input  logic signed [uaisd_pkg::VALUE_W-1:0] s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic                                 m_found,
    output logic [uaisd_pkg::POS_W-1:0]          m_position,
    output logic [uaisd_pkg::FILL_W-1:0]         m_fill_count
);

    // front -> back command handoff
    logic            cmd_valid;
    logic            cmd_pop;
    uaisd_pkg::cmd_t cmd;

    // back -> result register
    logic            res_valid;
    logic            res_ready;
    uaisd_pkg::res_t res;

    // result register (output stage)
    uaisd_pkg::res_t res_reg;
    logic            m_valid_reg;

    // Front: accept and decode transactions, hold them in a short queue.
    uaisd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_value   ($unsigned(s_value)),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back: run each command against the entry memory and fill count.
    uaisd_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // The back end may hand over a result whenever the output slot is empty
    // or is being drained in this cycle.
    assign res_ready = !m_valid_reg || m_ready;

    // Load the result register; hold it until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = res_reg.status;
    assign m_found      = res_reg.found;
    assign m_position   = res_reg.position;
    assign m_fill_count = res_reg.fill_count;

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking testbench for unsorted_array_insert_search_delete.
// Uses uaisd_pkg for the action and status codes and the result layout; needs the
// design sources and nothing else.
module tb_top;

    localparam int CAP         = 64;
    localparam int LIMIT       = 1_000_000;  // cycles before the run is declared hung
    localparam int SETTLE      = 200;        // longer than the slowest delete
    localparam int HOLD_CYCLES = 400;        // receiver back-pressure stretch
    localparam int MAX_SHOWN   = 10;

    // One directed row. Rows with typed set carry their expected result; the
    // others take the shadow table's answer.
    typedef struct {
        logic [1:0]                   act;
        logic [31:0]                  val;
        bit                           typed;
        logic [1:0]                   st;
        logic                         fnd;
        logic [uaisd_pkg::POS_W-1:0]  pos;
        logic [uaisd_pkg::FILL_W-1:0] fill;
    } step_t;

    // Random phase shape: item count, action mix in percent (the remainder is the
    // unused action), whether both sides run without idling, and whether the
    // receiver backs off at the start.
    typedef struct {
        int n;
        int ins_pct;
        int srch_pct;
        int del_pct;
        bit quiet;
        bit hold;
    } phase_t;

    logic                                 aclk;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_ready;
    logic [1:0]                           s_action = uaisd_pkg::ACT_INSERT;
    logic signed [uaisd_pkg::VALUE_W-1:0] s_value = '0;
    logic                                 m_valid;
    logic                                 m_ready = 1'b0;
    logic [1:0]                           m_status;
    logic                                 m_found;
    logic [uaisd_pkg::POS_W-1:0]          m_position;
    logic [uaisd_pkg::FILL_W-1:0]         m_fill_count;

    // Side information that travels with the transaction on the input channel.
    bit              cur_typed = 1'b0;
    uaisd_pkg::res_t cur_want  = '0;

    // Shadow copy of the block's table.
    logic [31:0] stored [CAP];
    int          stored_n = 0;

    uaisd_pkg::res_t pending_res[$];
    int   fail_cnt  = 0;
    int   cycle_cnt = 0;
    bit   quiet     = 1'b0;
    bit   want_hold = 1'b0;
    bit   hold_done = 1'b0;

    logic [31:0] value_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                    32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_00FF,
                                    32'hDEAD_BEEF, 32'h5555_5555};

    step_t plan [22] = '{
        '{uaisd_pkg::ACT_SEARCH, 32'h0000_0000, 1'b1, uaisd_pkg::ST_MISSING,
          1'b0, 6'd0, 7'd0},  // empty lookup
        '{uaisd_pkg::ACT_DELETE, 32'h8000_0000, 1'b1, uaisd_pkg::ST_MISSING,
          1'b0, 6'd0, 7'd0},  // empty delete
        '{uaisd_pkg::ACT_NONE,   32'h0000_0000, 1'b1, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},  // unused action
        '{uaisd_pkg::ACT_INSERT, 32'h8000_0000, 1'b1, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd1},
        '{uaisd_pkg::ACT_INSERT, 32'h7FFF_FFFF, 1'b1, uaisd_pkg::ST_DONE,
          1'b0, 6'd1, 7'd2},
        '{uaisd_pkg::ACT_INSERT, 32'h0000_0000, 1'b1, uaisd_pkg::ST_DONE,
          1'b0, 6'd2, 7'd3},
        '{uaisd_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b1, uaisd_pkg::ST_DONE,
          1'b0, 6'd3, 7'd4},
        '{uaisd_pkg::ACT_INSERT, 32'h7FFF_FFFF, 1'b1, uaisd_pkg::ST_DONE,
          1'b0, 6'd4, 7'd5},  // duplicate
        '{uaisd_pkg::ACT_SEARCH, 32'h7FFF_FFFF, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},  // first of two
        '{uaisd_pkg::ACT_SEARCH, 32'h7FFF_FFFE, 1'b1, uaisd_pkg::ST_MISSING,
          1'b0, 6'd0, 7'd5},  // near miss
        '{uaisd_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},
        '{uaisd_pkg::ACT_NONE,   32'hFFFF_FFFF, 1'b1, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd5},
        '{uaisd_pkg::ACT_DELETE, 32'h7FFF_FFFF, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},  // removes first copy
        '{uaisd_pkg::ACT_SEARCH, 32'h7FFF_FFFF, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},  // second copy moved
        '{uaisd_pkg::ACT_DELETE, 32'h8000_0000, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},  // head entry
        '{uaisd_pkg::ACT_DELETE, 32'hFFFF_FFFF, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},
        '{uaisd_pkg::ACT_DELETE, 32'h7FFF_FFFF, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},  // tail entry
        '{uaisd_pkg::ACT_DELETE, 32'h7FFF_FFFF, 1'b1, uaisd_pkg::ST_MISSING,
          1'b0, 6'd0, 7'd1},
        '{uaisd_pkg::ACT_DELETE, 32'h0000_0000, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},  // back to empty
        '{uaisd_pkg::ACT_INSERT, 32'h5A5A_5A5A, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},
        '{uaisd_pkg::ACT_NONE,   32'h8000_0000, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0},
        '{uaisd_pkg::ACT_SEARCH, 32'hA5A5_A5A5, 1'b0, uaisd_pkg::ST_DONE,
          1'b0, 6'd0, 7'd0}
    };

    // Fill to capacity and past it, churn near full with no idling, drain under
    // back-pressure, churn, drain to empty, churn again.
    phase_t phases [6] = '{
        '{160, 80, 10,  8, 1'b0, 1'b0},
        '{200, 34, 33, 31, 1'b1, 1'b0},
        '{150, 20, 30, 48, 1'b0, 1'b1},
        '{250, 40, 30, 28, 1'b0, 1'b0},
        '{150, 10, 20, 68, 1'b0, 1'b0},
        '{200, 50, 25, 23, 1'b0, 1'b0}
    };

    unsorted_array_insert_search_delete #(.CAPACITY(CAP)) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_position   (m_position),
        .m_fill_count (m_fill_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Apply one action to the shadow table and return the result it yields.
    // Equality is on all 32 bits; delete keeps the table packed.
    function automatic uaisd_pkg::res_t apply_action(input logic [1:0] act,
                                                     input logic [31:0] key);
        uaisd_pkg::res_t r;
        int              hit;
        r   = '0;
        hit = -1;
        case (act) inside
            uaisd_pkg::ACT_INSERT: begin
                if (stored_n >= CAP) begin
                    r.status = uaisd_pkg::ST_FULL;
                end else begin
                    stored[stored_n] = key;
                    r.position       = uaisd_pkg::POS_W'(stored_n);
                    stored_n++;
                end
            end
            uaisd_pkg::ACT_SEARCH, uaisd_pkg::ACT_DELETE: begin
                for (int i = 0; i < stored_n; i++)
                    if (hit < 0 && stored[i] == key)
                        hit = i;
                if (hit < 0) begin
                    r.status = uaisd_pkg::ST_MISSING;
                end else begin
                    r.found    = 1'b1;
                    r.position = uaisd_pkg::POS_W'(hit);
                    if (act == uaisd_pkg::ACT_DELETE) begin
                        for (int i = hit; i + 1 < stored_n; i++)
                            stored[i] = stored[i + 1];
                        stored_n--;
                    end
                end
            end
            default: ;  // unused action leaves the table alone
        endcase
        r.fill_count = uaisd_pkg::FILL_W'(stored_n);
        return r;
    endfunction

    // Favor keys that are in the table so searches and deletes mostly hit.
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (stored_n > 0 && r < 70)
            return stored[$urandom_range(stored_n - 1)];
        if (r < 85)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Offer one transaction. Entered and left at a falling edge; valid stays
    // high into the next item when no gap is drawn.
    task automatic push_item(input logic [1:0] act, input logic [31:0] val,
                             input bit typed, input uaisd_pkg::res_t want);
        while (!quiet && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_value   <= val;
        cur_typed <= typed;
        cur_want  <= want;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every outstanding result has been seen.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_res.size() != 0)
            @(negedge aclk);
    endtask

    // Input monitor: advance the shadow table on every accepted transaction and
    // queue what the block must answer.
    always @(posedge aclk) begin
        uaisd_pkg::res_t predicted;
        if (aresetn && s_valid && s_ready) begin
            predicted = apply_action(s_action, s_value);
            pending_res.push_back(cur_typed ? cur_want : predicted);
        end
    end

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        uaisd_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_SHOWN)
                    $display("unexpected result: status=%0d found=%0d pos=%0d fill=%0d",
                             m_status, m_found, m_position, m_fill_count);
            end else begin
                want = pending_res.pop_front();
                if (m_status !== want.status || m_found !== want.found ||
                    m_position !== want.position || m_fill_count !== want.fill_count) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("mismatch: want status=%0d found=%0d pos=%0d fill=%0d, %s",
                                 want.status, want.found, want.position, want.fill_count,
                                 $sformatf("got status=%0d found=%0d pos=%0d fill=%0d",
                                           m_status, m_found, m_position, m_fill_count));
                end
            end
        end
    end

    // Receiver: random back-pressure, none in quiet phases, and one long
    // hold-off on request while the sender keeps pushing.
    initial begin
        int hold_left;
        hold_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (want_hold && !hold_done && hold_left == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_done = 1'b1;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 25);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT) begin
            $display("unsorted_array_insert_search_delete test failed");
            $finish;
        end
    end

    initial begin
        uaisd_pkg::res_t want;
        logic [1:0]      act;
        logic [31:0]     val;
        int              r;

        // Hold reset at the start, then release it on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows: empty table, extremes, duplicates, head/tail deletes.
        foreach (plan[i]) begin
            want = {plan[i].st, plan[i].fnd, plan[i].pos, plan[i].fill};
            push_item(plan[i].act, plan[i].val, plan[i].typed, want);
        end
        drain();

        // Random phases, each drained before the next so the sender also
        // pauses with nothing outstanding.
        foreach (phases[p]) begin
            quiet = phases[p].quiet;
            if (phases[p].hold)
                want_hold = 1'b1;
            for (int k = 0; k < phases[p].n; k++) begin
                r = $urandom_range(99);
                if (r < phases[p].ins_pct) begin
                    act = uaisd_pkg::ACT_INSERT;
                    val = $urandom_range(1) ? value_pool[$urandom_range(7)] : $urandom;
                end else if (r < phases[p].ins_pct + phases[p].srch_pct) begin
                    act = uaisd_pkg::ACT_SEARCH;
                    val = pick_key();
                end else if (r < phases[p].ins_pct + phases[p].srch_pct
                                 + phases[p].del_pct) begin
                    act = uaisd_pkg::ACT_DELETE;
                    val = pick_key();
                end else begin
                    act = uaisd_pkg::ACT_NONE;
                    val = $urandom;
                end
                push_item(act, val, 1'b0, '0);
            end
            drain();
        end

        // Let any stray result show up before judging.
        repeat (SETTLE) @(negedge aclk);
        if (fail_cnt == 0 && pending_res.size() == 0)
            $display("unsorted_array_insert_search_delete test passed");
        else
            $display("unsorted_array_insert_search_delete test failed");
        $finish;
    end

endmodule
